// ----- rtl/aacr_pkg.sv -----
// shared types and constants for the anti-aliased circle arc rasterizer
package aacr_pkg;

    localparam int unsigned CFG_IDX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS = 64;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_RECT_A = 3'd0,
        REG_RECT_B = 3'd1,
        REG_RECT_C = 3'd2,
        REG_RECT_D = 3'd3,
        REG_CENTER_X = 3'd4,
        REG_CENTER_Y = 3'd5,
        REG_RADIUS = 3'd6,
        REG_BRUSH_ALPHA = 3'd7
    } t_reg_idx;

    localparam logic [7:0] FULL_ALPHA = 8'd255;

    // handshake between the top level and the square root unit
    typedef struct packed {
        logic start;
        logic [31:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic busy;
        logic [15:0] root;
    } t_sqrt_rsp;

endpackage

// ----- rtl/aacr_isqrt.sv -----
// iterative floor square root, two radicand bits per cycle
module aacr_isqrt
    import aacr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sqrt_req i_req,
    output t_sqrt_rsp o_rsp
);

    logic [31:0] r_rem;
    logic [31:0] r_res;
    logic [31:0] r_bit;
    logic        r_busy;
    logic [31:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_rem <= i_req.radicand;
            r_res <= '0;
            r_bit <= 32'h4000_0000;
        end else if (r_busy) begin
            if (r_rem >= trial) begin
                r_rem <= r_rem - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            if (r_bit == 32'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.root = r_res[15:0];

endmodule

// ----- rtl/antialiased_circle_arc_raster.sv -----
// top level: octant walk sequencer, mask test and pixel emission
// a column request runs the alpha, scan, hold, setup, square root and reduce steps in that
//   order; each visible pixel after the first must first release the held one to be emitted;
//   a closing step scans the four quadrants only, and a finished walk answers from idle with no
//   scan; no new request is taken until the sequencer is back in idle
// reset: synchronous active low; registers take their documented reset values
module antialiased_circle_arc_raster
    import aacr_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int RADIUS_BITS = 11
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_restart,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [15:0]       o_pixel_x,
    output logic signed [15:0]       o_pixel_y,
    output logic [7:0]               o_alpha,
    output logic                     o_visible,
    output logic                     o_walk_done,
    output logic                     o_last
);

    typedef enum logic [2:0] {
        S_IDLE, S_ALPHA, S_EMIT, S_CALC, S_SQRT, S_REDUCE, S_ROW, S_HOLD
    } t_state;

    logic [63:0] r_rect [4];
    logic [15:0] r_cx, r_cy;
    logic [RADIUS_BITS-1:0] r_radius;
    logic [7:0] r_brush;

    logic [RADIUS_BITS-1:0] r_col, r_row;
    logic [7:0] r_err;
    logic r_finished;

    t_state r_state;
    logic [4:0] r_slot;
    logic r_closing;
    logic r_any;
    logic [7:0] r_a1, r_a2;
    logic [1:0] r_aph;
    logic [15:0] r_prod;
    logic [31:0] r_real;
    logic signed [23:0] r_e;
    logic [11:0] r_k;
    logic r_sqrt_go;
    t_sqrt_req sqrt_req;
    t_sqrt_rsp sqrt_rsp;

    // output register; a held result waits until it is known whether it is the last
    logic r_ovalid;
    logic r_oheld;
    logic signed [15:0] r_ox, r_oy;
    logic [7:0] r_oa;
    logic r_ovis, r_odone, r_olast;

    // slot decode: quadrant = slot[3:2], kind = slot[1:0]
    logic signed [17:0] px, py, ox, oy, mag_a, mag_b;
    logic signed [17:0] sx_val, sy_val;
    logic [1:0] quad, kind;
    logic neg_x, neg_y;
    logic signed [COORD_BITS-1:0] wx, wy;
    logic signed [15:0] ex, ey;
    logic in_mask;
    logic [7:0] pa;
    logic last_slot;
    logic out_free;

    assign quad = r_slot[3:2];
    assign kind = r_slot[1:0];
    assign neg_x = quad[0];
    assign neg_y = quad[1];

    always_comb begin
        mag_a = 18'($unsigned(r_col));
        mag_b = 18'($unsigned(r_row));
        sx_val = 18'sd0;
        sy_val = 18'sd0;
        pa = r_a1;
        unique case (kind)
            2'd0: begin sx_val = mag_a; sy_val = mag_b; end
            2'd1: begin sx_val = mag_a; sy_val = mag_b - 18'sd1; pa = r_a2; end
            2'd2: begin sx_val = mag_b; sy_val = mag_a; end
            default: begin sx_val = mag_b - 18'sd1; sy_val = mag_a; pa = r_a2; end
        endcase
        if (r_closing) begin
            sx_val = mag_a;
            sy_val = mag_b;
            pa = r_a1;
        end
        px = neg_x ? -sx_val : sx_val;
        py = neg_y ? -sy_val : sy_val;
        ox = px + 18'(r_cx);
        oy = py + 18'(r_cy);
        wx = ox[COORD_BITS-1:0];
        wy = oy[COORD_BITS-1:0];
        ex = 16'(wx);
        ey = 16'(wy);
        in_mask = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (ex >= $signed(r_rect[i][15:0]) && ex <= $signed(r_rect[i][47:32]) &&
                ey >= $signed(r_rect[i][31:16]) && ey <= $signed(r_rect[i][63:48])) begin
                in_mask = 1'b1;
            end
        end
    end

    // closing step walks quadrants only (slot steps by 4)
    assign last_slot = r_closing ? (r_slot[3:2] == 2'd3) : (r_slot[3:0] == 4'd15);
    assign out_free = !r_ovalid || (i_ready && !r_oheld);
    assign o_ready = (r_state == S_IDLE) && out_free;

    assign sqrt_req.start = r_sqrt_go;
    assign sqrt_req.radicand = r_real;
    aacr_isqrt u_isqrt (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(sqrt_req), .o_rsp(sqrt_rsp));

    logic [RADIUS_BITS-1:0] col_nx;
    logic [2*RADIUS_BITS:0] rr;
    assign col_nx = r_col + 1'b1;
    assign rr = (2*RADIUS_BITS+1)'(r_radius) * (2*RADIUS_BITS+1)'(r_radius);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_rect[i] <= '0;
            r_cx <= '0;
            r_cy <= '0;
            r_radius <= '0;
            r_brush <= FULL_ALPHA;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_RECT_A: r_rect[0] <= i_cfg_data;
                REG_RECT_B: r_rect[1] <= i_cfg_data;
                REG_RECT_C: r_rect[2] <= i_cfg_data;
                REG_RECT_D: r_rect[3] <= i_cfg_data;
                REG_CENTER_X: r_cx <= i_cfg_data[15:0];
                REG_CENTER_Y: r_cy <= i_cfg_data[15:0];
                REG_RADIUS: r_radius <= i_cfg_data[RADIUS_BITS-1:0];
                default: r_brush <= i_cfg_data[7:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col <= '0;
            r_row <= '0;
            r_err <= '0;
            r_finished <= 1'b1;
            r_ovalid <= 1'b0;
            r_oheld <= 1'b0;
            r_sqrt_go <= 1'b0;
        end else begin
            logic ov;
            ov = r_ovalid;
            if (o_valid && i_ready) ov = 1'b0;
            r_sqrt_go <= (r_state == S_CALC);
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        logic fin;
                        fin = r_finished;
                        if (i_restart) begin
                            r_col <= '0;
                            r_row <= r_radius;
                            r_err <= '0;
                            fin = 1'b0;
                        end
                        r_finished <= fin;
                        r_slot <= '0;
                        r_any <= 1'b0;
                        r_aph <= '0;
                        r_closing <= i_restart ? (r_radius == '0) : !(r_col < r_row);
                        if (fin) begin
                            ov = 1'b1;
                            r_ox <= '0; r_oy <= '0; r_oa <= '0;
                            r_ovis <= 1'b0; r_odone <= 1'b1; r_olast <= 1'b1;
                        end else begin
                            r_prod <= 16'(FULL_ALPHA - (i_restart ? 8'd0 : r_err)) * 16'(r_brush);
                            r_state <= S_ALPHA;
                        end
                    end
                end
                S_ALPHA: begin
                    // divide by 255: (p + 1 + (p >> 8)) >> 8 is exact for p < 65535
                    if (r_aph == 2'd0) begin
                        r_a1 <= 8'((17'(r_prod) + 17'd1 + 17'(r_prod[15:8])) >> 8);
                        r_prod <= 16'(r_err) * 16'(r_brush);
                        r_aph <= 2'd1;
                    end else begin
                        r_a2 <= 8'((17'(r_prod) + 17'd1 + 17'(r_prod[15:8])) >> 8);
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    logic vis, put;
                    vis = in_mask && (r_brush != 8'd0);
                    put = vis || (last_slot && !r_any);
                    if (vis && r_ovalid && r_oheld) begin
                        // a newer pixel exists, so the held one is not the last
                        r_oheld <= 1'b0;
                    end else if (!put || out_free) begin
                        if (put) begin
                            ov = 1'b1;
                            r_oheld <= 1'b1;
                            r_ox <= vis ? ex : 16'sd0;
                            r_oy <= vis ? ey : 16'sd0;
                            r_oa <= vis ? pa : 8'd0;
                            r_ovis <= vis;
                            r_odone <= r_closing;
                            r_olast <= 1'b0;
                        end
                        if (vis) r_any <= 1'b1;
                        r_slot <= r_closing ? r_slot + 5'd4 : r_slot + 5'd1;
                        if (last_slot) begin
                            r_state <= S_HOLD;
                            if (r_closing) r_finished <= 1'b1;
                        end
                    end
                end
                S_HOLD: begin
                    // the held result is the newest of this request
                    r_olast <= 1'b1;
                    r_oheld <= 1'b0;
                    r_state <= r_closing ? S_IDLE : S_CALC;
                end
                S_CALC: begin
                    logic [2*RADIUS_BITS:0] c2;
                    c2 = (2*RADIUS_BITS+1)'(col_nx) * (2*RADIUS_BITS+1)'(col_nx);
                    r_col <= col_nx;
                    r_real <= (rr > c2) ? 32'(rr - c2) << 10 : 32'd0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (!r_sqrt_go && !sqrt_rsp.busy) begin
                        logic signed [23:0] e;
                        e = 24'(r_row) * 24'sd256 - (24'(sqrt_rsp.root) <<< 3);
                        r_e <= (e < 0) ? 24'sd0 : e;
                        r_state <= S_REDUCE;
                    end
                end
                S_REDUCE: begin
                    // e / 255 by reciprocal multiply, exact for e below 2^19
                    r_k <= 12'((40'(r_e[18:0]) * 40'd1052689) >> 28);
                    r_state <= S_ROW;
                end
                S_ROW: begin
                    // e - 255 * k equals e + k modulo 256
                    r_err <= r_e[7:0] + r_k[7:0];
                    r_row <= (12'(r_row) > r_k) ? RADIUS_BITS'(12'(r_row) - r_k) : '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            r_ovalid <= ov;
        end
    end

    assign o_valid = r_ovalid && !r_oheld;
    assign o_pixel_x = r_ox;
    assign o_pixel_y = r_oy;
    assign o_alpha = r_oa;
    assign o_visible = r_ovis;
    assign o_walk_done = r_odone;
    assign o_last = r_olast;

    ap_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("accept while busy");
    ap_sqrt_only_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_rsp.busy |-> (r_state == S_SQRT)) else $error("sqrt busy out of place");
    ap_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_err != FULL_ALPHA)) else $error("error not reduced");
    ap_held_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oheld |-> (r_state == S_EMIT || r_state == S_HOLD)) else $error("held out of scan");

endmodule
